FILE: src/chroma_smoother_with_gain_follower_defines.svh
// assertion macros for the chroma smoother back rtl
// no dependencies
`ifndef CHROMA_SMOOTHER_WITH_GAIN_FOLLOWER_DEFINES_SVH
`define CHROMA_SMOOTHER_WITH_GAIN_FOLLOWER_DEFINES_SVH

// assert that a implies b on the next cycle
`define CSGF_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

// assert that a implies b in the same cycle
`define CSGF_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`endif

FILE: src/csgf_pkg.sv
// types and constants for the chroma smoother with gain follower
// no dependencies
`timescale 1ns / 1ps
package csgf_pkg;
    localparam int BIN_COUNT = 12;
    localparam logic [15:0] FOLLOWER_RESET = 16'd9830;
    localparam logic [2:0] REG_SMOOTH = 3'd0;
    localparam logic [2:0] REG_ATTACK = 3'd1;
    localparam logic [2:0] REG_DECAY = 3'd2;
    localparam logic [2:0] REG_FLOOR = 3'd3;
    localparam logic [2:0] REG_SILENCE = 3'd4;

    // one finished frame handed from the front to the back
    typedef struct packed {
        logic [7:0] zone;
        logic       audio;
    } t_frame;

    typedef struct packed {
        logic [15:0] smooth_alpha;
        logic [15:0] attack_alpha;
        logic [15:0] decay_alpha;
        logic [15:0] follower_floor;
        logic [15:0] silence_threshold;
    } t_cfg;

    function automatic logic [15:0] clamp_unit(input logic signed [17:0] v);
        if (v < 0) return 16'd0;
        if (v > 18'sd65535) return 16'hFFFF;
        return v[15:0];
    endfunction
endpackage

FILE: src/csgf_front.sv
// front: stores the bins of one frame and queues finished frames
// depends on csgf_pkg
`timescale 1ns / 1ps
module csgf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_zone,
    input  logic                  i_audio_present,
    input  logic signed [17:0]    i_raw_value,
    input  logic signed [17:0]    i_fallback_value,
    input  logic                  i_last,
    output logic                  o_frm_valid,
    output csgf_pkg::t_frame      o_frm,
    input  logic                  i_frm_take,
    input  logic [3:0]            i_rd_idx,
    output logic signed [17:0]    o_rd_raw,
    output logic signed [17:0]    o_rd_fb
);
    import csgf_pkg::*;

    logic signed [17:0] r_raw [BIN_COUNT];
    logic signed [17:0] r_fb [BIN_COUNT];
    logic [3:0] r_cnt;
    logic r_q_valid;
    t_frame r_q;
    logic acc;

    // one-deep frame queue; bin store is shared, so hold input until the back
    // has finished reading the bins of the waiting frame
    assign o_stall = r_q_valid;
    assign acc = i_valid && !o_stall;
    assign o_frm_valid = r_q_valid;
    assign o_frm = r_q;

    always_ff @(posedge i_clk) begin
        if (acc && r_cnt < 4'(BIN_COUNT)) begin
            r_raw[r_cnt] <= i_raw_value;
            r_fb[r_cnt] <= i_fallback_value;
        end
        o_rd_raw <= r_raw[i_rd_idx];
        o_rd_fb <= r_fb[i_rd_idx];
        if (acc && i_last) begin
            r_q.zone <= i_zone;
            r_q.audio <= i_audio_present;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (acc) begin
                if (i_last) r_cnt <= '0;
                else if (r_cnt < 4'(BIN_COUNT)) r_cnt <= r_cnt + 4'd1;
            end
            if (acc && i_last) r_q_valid <= 1'b1;
            else if (i_frm_take) r_q_valid <= 1'b0;
        end
    end
endmodule

FILE: src/csgf_back.sv
// back: smoothing, follower update and serial divide per frame
// depends on csgf_pkg, csgf_front bin read port, defines header
`timescale 1ns / 1ps
`include "chroma_smoother_with_gain_follower_defines.svh"
module csgf_back #(
    parameter int ZONE_COUNT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csgf_pkg::t_cfg        i_cfg,
    input  logic                  i_frm_valid,
    input  csgf_pkg::t_frame      i_frm,
    output logic                  o_frm_take,
    output logic [3:0]            o_rd_idx,
    input  logic signed [17:0]    i_rd_raw,
    input  logic signed [17:0]    i_rd_fb,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_bin_index,
    output logic [15:0]           o_level,
    output logic [15:0]           o_follower_level,
    output logic                  o_used_fallback,
    output logic                  o_last_res
);
    import csgf_pkg::*;

    localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int SD = ZONE_COUNT * BIN_COUNT;
    localparam int SW = $clog2(SD);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAX  = 3'd1;
    localparam logic [2:0] S_SMO  = 3'd2;
    localparam logic [2:0] S_FOL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;

    logic [2:0] r_st;
    logic [3:0] r_i;
    logic [1:0] r_ph;
    logic [5:0] r_dc;
    logic [ZW-1:0] r_z;
    logic r_fb;
    logic signed [17:0] r_rmax;
    logic [15:0] r_fmax;
    logic [15:0] r_f;
    logic [15:0] r_s;
    logic [33:0] r_rem;
    logic [16:0] r_quo;
    logic [15:0] r_fol [ZONE_COUNT];
    logic [15:0] r_sm [SD];
    logic [SW-1:0] r_clr;
    logic [15:0] r_smrd;
    logic [SW-1:0] sm_addr;
    logic [SW-1:0] base;
    logic [32:0] r_p1, r_p2;
    logic [33:0] sum;
    logic [15:0] blend_res;
    logic [15:0] flr;
    logic [16:0] nb;
    logic [15:0] x;
    logic out_rdy;
    logic emit;

    assign base = SW'(r_z) * SW'(BIN_COUNT);
    assign sm_addr = base + SW'(r_i);
    assign o_rd_idx = r_i;
    // the frame is released once its bins are no longer needed
    assign o_frm_take = ((r_st == S_IDLE) && i_frm_valid && !i_frm.audio) ||
                        ((r_st == S_SMO) && (r_ph == 2'd3) && (r_i == 4'(BIN_COUNT - 1)));
    assign sum = {1'b0, r_p1} + {1'b0, r_p2} + 34'd32768;
    assign blend_res = sum[31:16];
    assign flr = (i_cfg.follower_floor == 16'd0) ? 16'd1 : i_cfg.follower_floor;
    assign x = clamp_unit(r_fb ? i_rd_fb : i_rd_raw);
    assign nb = 17'd65536 - {1'b0, (r_fmax > r_f) ? i_cfg.attack_alpha : i_cfg.decay_alpha};
    assign out_rdy = !o_valid || !i_stall;
    assign emit = out_rdy && (((r_st == S_DIV) && (r_ph == 2'd2) && (r_dc == 6'd0)) ||
                              (r_st == S_OUT));

    always_ff @(posedge i_clk) begin
        r_smrd <= r_sm[sm_addr];
        if (r_st == S_CLR) r_sm[r_clr] <= '0;
        else if (r_st == S_SMO && r_ph == 2'd3) r_sm[sm_addr] <= blend_res;

        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            o_valid <= 1'b0;
            for (int k = 0; k < ZONE_COUNT; k++) r_fol[k] <= FOLLOWER_RESET;
        end else begin
            if (emit) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(SD - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_frm_valid) begin
                    r_z <= (i_frm.zone < 8'(ZONE_COUNT)) ? ZW'(i_frm.zone) : '0;
                    r_i <= '0;
                    r_ph <= '0;
                    r_rmax <= '0;
                    r_fmax <= '0;
                    r_st <= i_frm.audio ? S_MAX : S_OUT;
                    r_f <= '0;
                    r_fb <= 1'b0;
                end
                S_MAX: begin
                    // ph0 issues read, ph1 uses registered data
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else begin
                        r_ph <= '0;
                        if (i_rd_raw > r_rmax) r_rmax <= i_rd_raw;
                        if (r_i == 4'(BIN_COUNT - 1)) begin
                            r_i <= '0;
                            r_st <= S_SMO;
                            r_fb <= ((i_rd_raw > r_rmax) ? i_rd_raw : r_rmax)
                                    < $signed({2'b00, i_cfg.silence_threshold});
                        end else r_i <= r_i + 4'd1;
                    end
                end
                S_SMO: begin
                    unique case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: begin
                            r_p1 <= 33'(r_smrd) * 33'(17'd65536 - {1'b0, i_cfg.smooth_alpha});
                            r_p2 <= {17'd0, x} * {17'd0, i_cfg.smooth_alpha};
                            r_ph <= 2'd2;
                        end
                        2'd2: r_ph <= 2'd3;
                        default: begin
                            r_ph <= '0;
                            if (blend_res > r_fmax) r_fmax <= blend_res;
                            if (r_i == 4'(BIN_COUNT - 1)) begin
                                r_i <= '0;
                                r_st <= S_FOL;
                            end else r_i <= r_i + 4'd1;
                        end
                    endcase
                end
                S_FOL: begin
                    if (r_ph == 2'd0) begin
                        r_f <= r_fol[r_z];
                        r_ph <= 2'd1;
                    end else if (r_ph == 2'd1) begin
                        r_p1 <= 33'(r_f) * 33'(nb);
                        r_p2 <= {17'd0, r_fmax} *
                                {17'd0, (r_fmax > r_f) ? i_cfg.attack_alpha : i_cfg.decay_alpha};
                        r_ph <= 2'd2;
                    end else begin
                        r_f <= (blend_res < flr) ? flr : blend_res;
                        r_fol[r_z] <= (blend_res < flr) ? flr : blend_res;
                        r_ph <= '0;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (r_ph == 2'd1) begin
                        r_s <= r_smrd;
                        r_rem <= {2'b0, r_smrd, 16'd0} + {19'd0, r_f[15:1]};
                        r_quo <= '0;
                        r_dc <= 6'd34;
                        r_ph <= 2'd2;
                    end else if (r_dc != 6'd0) begin
                        r_dc <= r_dc - 6'd1;
                        if ((r_rem >> (r_dc - 6'd1)) >= {18'd0, r_f}) begin
                            r_rem <= r_rem - ({18'd0, r_f} << (r_dc - 6'd1));
                            r_quo <= {r_quo[15:0], 1'b1};
                        end else r_quo <= {r_quo[15:0], 1'b0};
                    end else if (out_rdy) begin
                        o_bin_index <= r_i;
                        o_level <= (r_quo[16] || r_s >= r_f) ?
                                   ((r_s >= r_f) ? 16'hFFFF : r_quo[15:0]) : r_quo[15:0];
                        o_follower_level <= r_f;
                        o_used_fallback <= r_fb;
                        o_last_res <= (r_i == 4'(BIN_COUNT - 1));
                        r_ph <= '0;
                        if (r_i == 4'(BIN_COUNT - 1)) r_st <= S_IDLE;
                        else r_i <= r_i + 4'd1;
                    end
                end
                default: begin
                    if (out_rdy) begin
                        o_bin_index <= r_i;
                        o_level <= '0;
                        o_follower_level <= '0;
                        o_used_fallback <= 1'b0;
                        o_last_res <= (r_i == 4'(BIN_COUNT - 1));
                        if (r_i == 4'(BIN_COUNT - 1)) r_st <= S_IDLE;
                        else r_i <= r_i + 4'd1;
                    end
                end
            endcase
        end
    end

    `CSGF_ASSERT_SAME(a_take_state, i_clk, i_rst_n, o_frm_take, r_st == S_IDLE || r_st == S_SMO)
    `CSGF_ASSERT_SAME(a_fol_floor, i_clk, i_rst_n, o_valid && o_follower_level != 16'd0,
        o_follower_level >= flr)
    `CSGF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_level) && $stable(o_bin_index))
endmodule

FILE: src/chroma_smoother_with_gain_follower.sv
// top level: config registers, front bin store and back processing
// depends on csgf_pkg, csgf_front, csgf_back
`timescale 1ns / 1ps
// pacing: a frame of twelve levels is limited by the serial divide per bin and the
// four-phase smoothing per bin; input stalls until smoothing ends
// reset: synchronous active low; then a clear pass over all ZONE_COUNT*12 entries
// of the smoothed-bin memory before the first frame is processed
module chroma_smoother_with_gain_follower #(
    parameter int ZONE_COUNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_zone,
    input  logic               i_audio_present,
    input  logic signed [17:0] i_raw_value,
    input  logic signed [17:0] i_fallback_value,
    input  logic               i_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_bin_index,
    output logic [15:0]        o_level,
    output logic [15:0]        o_follower_level,
    output logic               o_used_fallback,
    output logic               o_last_res
);
    import csgf_pkg::*;

    t_cfg r_cfg;
    t_frame frm;
    logic frm_valid, frm_take;
    logic [3:0] rd_idx;
    logic signed [17:0] rd_raw, rd_fb;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smooth_alpha <= 16'd10059;
            r_cfg.attack_alpha <= 16'd10363;
            r_cfg.decay_alpha <= 16'd1188;
            r_cfg.follower_floor <= 16'd2621;
            r_cfg.silence_threshold <= 16'd7;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SMOOTH:  r_cfg.smooth_alpha <= i_cfg_data;
                REG_ATTACK:  r_cfg.attack_alpha <= i_cfg_data;
                REG_DECAY:   r_cfg.decay_alpha <= i_cfg_data;
                REG_FLOOR:   r_cfg.follower_floor <= i_cfg_data;
                REG_SILENCE: r_cfg.silence_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    csgf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_zone(i_zone), .i_audio_present(i_audio_present),
        .i_raw_value(i_raw_value), .i_fallback_value(i_fallback_value),
        .i_last(i_last), .o_frm_valid(frm_valid), .o_frm(frm),
        .i_frm_take(frm_take), .i_rd_idx(rd_idx), .o_rd_raw(rd_raw), .o_rd_fb(rd_fb)
    );

    csgf_back #(.ZONE_COUNT(ZONE_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_frm_valid(frm_valid), .i_frm(frm), .o_frm_take(frm_take),
        .o_rd_idx(rd_idx), .i_rd_raw(rd_raw), .i_rd_fb(rd_fb),
        .o_valid(o_valid), .i_stall(i_stall), .o_bin_index(o_bin_index),
        .o_level(o_level), .o_follower_level(o_follower_level),
        .o_used_fallback(o_used_fallback), .o_last_res(o_last_res)
    );
endmodule
